@@ rtl/core/tlvx_pkg.sv @@
package tlvx_pkg;

	localparam int unsigned NUM_TAGS_DEF    = 8;
	localparam int unsigned MAX_TAG_LEN_DEF = 16;
	localparam int unsigned OUT_DEPTH       = 4;

	localparam logic [31:0] MAGIC_RST       = 32'h536b_616e;
	localparam logic [7:0]  TYPE_MASK_RST   = 8'h0f;
	localparam logic [7:0]  LEN_MASK_RST    = 8'h30;
	localparam logic [7:0]  LEN8_RST        = 8'h20;
	localparam logic [7:0]  LEN16_RST       = 8'h10;
	localparam logic [7:0]  LEN32_RST       = 8'h00;
	localparam logic [7:0]  NULL_RST        = 8'h04;
	localparam logic [3:0]  TAGS_USE_RST    = 4'd0;

	localparam logic       REQ_TAG_WRITE = 1'b0;
	localparam logic       REQ_MSG_BYTE  = 1'b1;
	localparam logic       KIND_MATCH    = 1'b0;
	localparam logic       KIND_SUMMARY  = 1'b1;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_BAD_MAGIC = 2'd1,
		ST_TRUNC     = 2'd2,
		ST_BAD_LEN   = 2'd3
	} status_t;

	typedef enum logic [3:0] {
		REG_MAGIC       = 4'd0,
		REG_TYPE_MASK   = 4'd1,
		REG_LEN_MASK    = 4'd2,
		REG_LEN8        = 4'd3,
		REG_LEN16       = 4'd4,
		REG_LEN32       = 4'd5,
		REG_NULL        = 4'd6,
		REG_TAGS_USE    = 4'd7
	} reg_idx_t;

	typedef enum logic [2:0] {
		PH_MAGIC,
		PH_TAGLEN,
		PH_TAG,
		PH_TYPE,
		PH_LEN,
		PH_DATA,
		PH_DONE
	} phase_t;

	typedef struct packed {
		logic [31:0] magic_word;
		logic [7:0]  type_mask;
		logic [7:0]  len_mask;
		logic [7:0]  len8_code;
		logic [7:0]  len16_code;
		logic [7:0]  len32_code;
		logic [7:0]  null_code;
		logic [3:0]  tags_in_use;
	} cfg_t;

	typedef struct packed {
		logic        kind;
		logic [2:0]  slot;
		logic [7:0]  code;
		logic [31:0] offset;
		logic [31:0] len;
		logic [1:0]  status;
		logic [3:0]  count;
		logic        last;
	} result_t;

	typedef struct packed {
		logic    [1:0] num;
		result_t       r0;
		result_t       r1;
	} push_t;

endpackage

@@ rtl/core/tlvx_tag_store.sv @@
module tlvx_tag_store #(
	parameter int unsigned NUM_TAGS    = tlvx_pkg::NUM_TAGS_DEF,
	parameter int unsigned MAX_TAG_LEN = tlvx_pkg::MAX_TAG_LEN_DEF
) (
	input  logic                clk,
	input  logic                wr_en,
	input  logic [2:0]          wr_slot,
	input  logic [3:0]          wr_pos,
	input  logic [4:0]          wr_len,
	input  logic [7:0]          wr_byte,
	input  logic [7:0]          cmp_byte,
	input  logic [7:0]          cmp_pos,
	output logic [NUM_TAGS-1:0] len_hit,
	output logic [NUM_TAGS-1:0] byte_hit
);
	import tlvx_pkg::*;

	localparam int unsigned SW  = (NUM_TAGS > 1) ? $clog2(NUM_TAGS) : 1;
	localparam int unsigned TPW = (MAX_TAG_LEN > 1) ? $clog2(MAX_TAG_LEN) : 1;

	logic [7:0] bytes_q [NUM_TAGS][MAX_TAG_LEN];
	logic [4:0] lens_q  [NUM_TAGS];
	logic [5:0] slot6;
	logic [7:0] pos8;

	assign slot6 = 6'(wr_slot);
	assign pos8  = 8'(wr_pos);

	always_ff @(posedge clk) begin
		if (wr_en && (slot6 < 6'(NUM_TAGS))) begin
			lens_q[slot6[SW-1:0]] <= wr_len;
			if (pos8 < 8'(MAX_TAG_LEN)) begin
				bytes_q[slot6[SW-1:0]][pos8[TPW-1:0]] <= wr_byte;
			end
		end
	end

	// out-of-range tag bytes never match; stored lengths over the max never match
	always_comb begin
		for (int s = 0; s < NUM_TAGS; s++) begin
			len_hit[s]  = (8'(lens_q[s]) == cmp_byte) && (cmp_byte <= 8'(MAX_TAG_LEN));
			byte_hit[s] = (cmp_pos < 8'(MAX_TAG_LEN))
				&& (bytes_q[s][cmp_pos[TPW-1:0]] == cmp_byte);
		end
	end

endmodule

@@ rtl/core/tlvx_parser.sv @@
module tlvx_parser #(
	parameter int unsigned NUM_TAGS = tlvx_pkg::NUM_TAGS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 step,
	input  logic [7:0]           b,
	input  logic                 msg_last,
	input  tlvx_pkg::cfg_t       cfg,
	input  logic [NUM_TAGS-1:0]  len_hit,
	input  logic [NUM_TAGS-1:0]  byte_hit,
	output logic [7:0]           cmp_pos,
	output tlvx_pkg::push_t      push
);
	import tlvx_pkg::*;

	phase_t              phase_q, phase_n;
	logic [31:0]         off_q, off_n, shift_q, shift_n, rem_q, rem_n, start_q, start_n;
	logic [7:0]          fc_q, fc_n, tlen_q, tlen_n, code_q, code_n;
	logic [NUM_TAGS-1:0] cand_q, cand_n, found_q, found_n, act;
	logic [1:0]          err_q, err_n;

	logic                do_fin, m_valid;
	logic [31:0]         fin_off, fin_len;
	logic [7:0]          lc;
	logic [5:0]          n_act;
	logic [2:0]          low_idx;
	logic [5:0]          pop;
	result_t             m_res, s_res;
	logic [1:0]          st;

	// active slots: tags_in_use clipped to NUM_TAGS
	always_comb begin
		n_act = (6'(cfg.tags_in_use) > 6'(NUM_TAGS)) ? 6'(NUM_TAGS) : 6'(cfg.tags_in_use);
		for (int s = 0; s < NUM_TAGS; s++) begin
			act[s] = (6'(s) < n_act);
		end
	end

	always_comb begin
		low_idx = '0;
		for (int s = NUM_TAGS - 1; s >= 0; s--) begin
			if (cand_q[s]) begin
				low_idx = 3'(s);
			end
		end
	end

	assign cmp_pos = fc_q;

	always_comb begin
		phase_n = phase_q;
		off_n   = off_q + 32'd1;
		shift_n = shift_q;
		rem_n   = rem_q;
		start_n = start_q;
		fc_n    = fc_q;
		tlen_n  = tlen_q;
		code_n  = code_q;
		cand_n  = cand_q;
		found_n = found_q;
		err_n   = err_q;
		do_fin  = 1'b0;
		fin_off = '0;
		fin_len = '0;
		lc      = b & cfg.len_mask;
		m_valid = 1'b0;
		pop     = '0;
		st      = ST_OK;
		unique case (phase_q)
			PH_MAGIC: begin
				if ((off_q == '0) && ((found_q & act) == act)) begin
					phase_n = PH_DONE;
				end else begin
					shift_n = {shift_q[23:0], b};
					fc_n    = fc_q + 8'd1;
					if (fc_n >= 8'd4) begin
						fc_n = '0;
						if (shift_n != cfg.magic_word) begin
							err_n   = ST_BAD_MAGIC;
							phase_n = PH_DONE;
						end else begin
							phase_n = PH_TAGLEN;
						end
					end
				end
			end
			PH_TAGLEN: begin
				tlen_n  = b;
				fc_n    = '0;
				cand_n  = len_hit & act;
				phase_n = (b == '0) ? PH_TYPE : PH_TAG;
			end
			PH_TAG: begin
				cand_n = cand_q & byte_hit;
				fc_n   = fc_q + 8'd1;
				if (fc_n >= tlen_q) begin
					phase_n = PH_TYPE;
				end
			end
			PH_TYPE: begin
				code_n  = b & cfg.type_mask;
				shift_n = '0;
				if (code_n == cfg.null_code) begin
					do_fin = 1'b1;
				end else if (lc == cfg.len8_code) begin
					fc_n = 8'd1;  phase_n = PH_LEN;
				end else if (lc == cfg.len16_code) begin
					fc_n = 8'd2;  phase_n = PH_LEN;
				end else if (lc == cfg.len32_code) begin
					fc_n = 8'd4;  phase_n = PH_LEN;
				end else begin
					err_n   = ST_BAD_LEN;
					phase_n = PH_DONE;
				end
			end
			PH_LEN: begin
				shift_n = {shift_q[23:0], b};
				fc_n    = fc_q - 8'd1;
				if (fc_n == '0) begin
					rem_n   = shift_n;
					start_n = off_q + 32'd1;
					if (shift_n == '0) begin
						do_fin  = 1'b1;
						fin_off = start_n;
					end else begin
						phase_n = PH_DATA;
					end
				end
			end
			PH_DATA: begin
				rem_n = rem_q - 32'd1;
				if (rem_n == '0) begin
					do_fin  = 1'b1;
					fin_off = start_q;
					fin_len = shift_q;
				end
			end
			default: ;
		endcase

		// item complete: lowest candidate reports once
		if (do_fin) begin
			if ((cand_q != '0) && !found_q[low_idx]) begin
				found_n[low_idx] = 1'b1;
				m_valid          = 1'b1;
			end
			phase_n = ((found_n & act) == act) ? PH_DONE : PH_TAGLEN;
		end

		for (int s = 0; s < NUM_TAGS; s++) begin
			pop = pop + 6'((found_n[s] & act[s]));
		end

		if (err_n != '0) begin
			st = err_n;
		end else if ((phase_n != PH_TAGLEN) && (phase_n != PH_DONE)) begin
			st = ST_TRUNC;
		end

		m_res = '{kind: KIND_MATCH, slot: low_idx, code: code_n, offset: fin_off,
			len: fin_len, status: ST_OK, count: pop[3:0], last: 1'b0};
		s_res = '{kind: KIND_SUMMARY, slot: '0, code: '0, offset: '0, len: '0,
			status: st, count: pop[3:0], last: 1'b1};

		push.r0  = m_valid ? m_res : s_res;
		push.r1  = s_res;
		push.num = step ? (2'(m_valid) + 2'(msg_last)) : 2'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_MAGIC;
			off_q   <= '0;
			shift_q <= '0;
			rem_q   <= '0;
			start_q <= '0;
			fc_q    <= '0;
			tlen_q  <= '0;
			code_q  <= '0;
			cand_q  <= '0;
			found_q <= '0;
			err_q   <= '0;
		end else if (step) begin
			if (msg_last) begin
				phase_q <= PH_MAGIC;
				off_q   <= '0;
				shift_q <= '0;
				rem_q   <= '0;
				start_q <= '0;
				fc_q    <= '0;
				tlen_q  <= '0;
				code_q  <= '0;
				cand_q  <= '0;
				found_q <= '0;
				err_q   <= '0;
			end else begin
				phase_q <= phase_n;
				off_q   <= off_n;
				shift_q <= shift_n;
				rem_q   <= rem_n;
				start_q <= start_n;
				fc_q    <= fc_n;
				tlen_q  <= tlen_n;
				code_q  <= code_n;
				cand_q  <= cand_n;
				found_q <= found_n;
				err_q   <= err_n;
			end
		end
	end

`ifndef SYNTHESIS
	a_clear_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(step && msg_last) |=> (phase_q == PH_MAGIC && found_q == '0))
		else $error("message state not cleared after last byte");
	a_no_match_when_done: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_DONE) |-> !m_valid)
		else $error("match reported after parsing stopped");
`endif

endmodule

@@ rtl/core/tlvx_out_fifo.sv @@
module tlvx_out_fifo (
	input  logic              clk,
	input  logic              arst_n,
	input  tlvx_pkg::push_t   push,
	input  logic              pop,
	output logic              out_valid,
	output tlvx_pkg::result_t out_data,
	output logic              room2
);
	import tlvx_pkg::*;

	localparam int unsigned PW = $clog2(OUT_DEPTH);

	result_t       mem_q [OUT_DEPTH];
	logic [PW-1:0] wp_q, rp_q, wp1;
	logic [PW:0]   cnt_q;
	logic          do_pop;

	assign wp1       = wp_q + PW'(1);
	assign out_valid = (cnt_q != '0);
	assign out_data  = mem_q[rp_q];
	assign do_pop    = pop && out_valid;
	assign room2     = (cnt_q <= (PW+1)'(OUT_DEPTH - 2));

	always_ff @(posedge clk) begin
		if (push.num != 2'd0) begin
			mem_q[wp_q] <= push.r0;
		end
		if (push.num == 2'd2) begin
			mem_q[wp1] <= push.r1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			wp_q  <= wp_q + PW'(push.num);
			rp_q  <= rp_q + PW'(do_pop);
			cnt_q <= cnt_q + (PW+1)'(push.num) - (PW+1)'(do_pop);
		end
	end

`ifndef SYNTHESIS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		(push.num != 2'd0) |-> ((cnt_q + (PW+1)'(push.num)) <= (PW+1)'(OUT_DEPTH)))
		else $error("result queue overflow");
`endif

endmodule

@@ rtl/core/tlv_message_tag_extractor_top.sv @@
// TLV tag extractor. Send search tag bytes (req_type 0) and message bytes
// (req_type 1) on the input channel; one transfer is taken per clock while
// the result queue has room. Each transfer goes to an input register and is
// parsed from there against all tag slots in parallel, and a new transfer is
// accepted every cycle as long as the four-entry result queue has room for
// two results. A byte yields at most a match report and, on the byte marked
// msg_last, an end-of-message summary (last = 1). A result is written into
// the result queue when its byte is parsed and is shown at the outputs from
// there. Registers are written through the cfg channel (always ready); the
// user must write them only while the block is idle, which is not enforced.
module tlv_message_tag_extractor_top #(
	parameter int unsigned NUM_TAGS    = tlvx_pkg::NUM_TAGS_DEF,
	parameter int unsigned MAX_TAG_LEN = tlvx_pkg::MAX_TAG_LEN_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// input channel
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        req_type,
	input  logic [2:0]  tag_slot,
	input  logic [3:0]  tag_pos,
	input  logic [4:0]  tag_length,
	input  logic [7:0]  data_byte,
	input  logic        msg_last,
	// result channel
	output logic        out_valid,
	input  logic        out_ready,
	output logic        result_kind,
	output logic [2:0]  match_slot,
	output logic [7:0]  type_code,
	output logic [31:0] data_offset,
	output logic [31:0] data_len,
	output logic [1:0]  status,
	output logic [3:0]  found_count,
	output logic        last,
	// configuration
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [3:0]  cfg_index,
	input  logic [31:0] cfg_data
);
	import tlvx_pkg::*;

	cfg_t                cfg_q;
	logic                s1_valid, s1_fire, room2;
	logic                req_s1, last_s1;
	logic [2:0]          slot_s1;
	logic [3:0]          pos_s1;
	logic [4:0]          tlen_s1;
	logic [7:0]          byte_s1, cmp_pos;
	logic [NUM_TAGS-1:0] len_hit, byte_hit;
	push_t               push;
	result_t             res;

	assign cfg_ready = 1'b1;

	// register file; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{magic_word: MAGIC_RST, type_mask: TYPE_MASK_RST,
				len_mask: LEN_MASK_RST, len8_code: LEN8_RST,
				len16_code: LEN16_RST, len32_code: LEN32_RST,
				null_code: NULL_RST, tags_in_use: TAGS_USE_RST};
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_MAGIC:       cfg_q.magic_word  <= cfg_data;
				REG_TYPE_MASK:   cfg_q.type_mask   <= cfg_data[7:0];
				REG_LEN_MASK:    cfg_q.len_mask    <= cfg_data[7:0];
				REG_LEN8:        cfg_q.len8_code   <= cfg_data[7:0];
				REG_LEN16:       cfg_q.len16_code  <= cfg_data[7:0];
				REG_LEN32:       cfg_q.len32_code  <= cfg_data[7:0];
				REG_NULL:        cfg_q.null_code   <= cfg_data[7:0];
				REG_TAGS_USE:    cfg_q.tags_in_use <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	// input stage: parsed when the result queue can take two results
	assign s1_fire  = s1_valid && room2;
	assign in_ready = !s1_valid || s1_fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid <= 1'b0;
		end else if (in_ready) begin
			s1_valid <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			req_s1  <= req_type;
			slot_s1 <= tag_slot;
			pos_s1  <= tag_pos;
			tlen_s1 <= tag_length;
			byte_s1 <= data_byte;
			last_s1 <= msg_last;
		end
	end

	tlvx_tag_store #(.NUM_TAGS(NUM_TAGS), .MAX_TAG_LEN(MAX_TAG_LEN)) u_store (
		.clk      (clk),
		.wr_en    (s1_fire && (req_s1 == REQ_TAG_WRITE)),
		.wr_slot  (slot_s1),
		.wr_pos   (pos_s1),
		.wr_len   (tlen_s1),
		.wr_byte  (byte_s1),
		.cmp_byte (byte_s1),
		.cmp_pos  (cmp_pos),
		.len_hit  (len_hit),
		.byte_hit (byte_hit)
	);

	tlvx_parser #(.NUM_TAGS(NUM_TAGS)) u_parser (
		.clk      (clk),
		.arst_n   (arst_n),
		.step     (s1_fire && (req_s1 == REQ_MSG_BYTE)),
		.b        (byte_s1),
		.msg_last (last_s1),
		.cfg      (cfg_q),
		.len_hit  (len_hit),
		.byte_hit (byte_hit),
		.cmp_pos  (cmp_pos),
		.push     (push)
	);

	tlvx_out_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.pop       (out_ready),
		.out_valid (out_valid),
		.out_data  (res),
		.room2     (room2)
	);

	assign result_kind = res.kind;
	assign match_slot  = res.slot;
	assign type_code   = res.code;
	assign data_offset = res.offset;
	assign data_len    = res.len;
	assign status      = res.status;
	assign found_count = res.count;
	assign last        = res.last;

`ifndef SYNTHESIS
	a_stall_holds_stage: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (s1_valid && !room2))
		else $error("input stalled without a full queue");
	a_kind_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (last == result_kind))
		else $error("last flag disagrees with result kind");
`endif

endmodule
